/* src/amx_pkg.sv */
package amx_pkg;

  // Machine sizes (all powers of two)
  localparam int DATA_DEPTH = 256;
  localparam int PROG_DEPTH = 256;
  localparam int WORD_BITS  = 32;

  localparam int DADDR_W = $clog2(DATA_DEPTH);
  localparam int PC_W    = $clog2(PROG_DEPTH);

  // Port field widths
  localparam int OP_W      = 4;
  localparam int IN_ADDR_W = 8;
  localparam int IMM_W     = 32;
  localparam int TGT_W     = 8;
  localparam int OUT_W     = 32;
  localparam int OUT_PC_W  = 8;

  typedef logic [OP_W-1:0]             op_t;
  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [DADDR_W-1:0]          daddr_t;
  typedef logic [PC_W-1:0]             pc_t;

  // Opcodes
  localparam op_t OP_DEC = 4'd0;
  localparam op_t OP_LDA = 4'd1;
  localparam op_t OP_LDB = 4'd2;
  localparam op_t OP_LDI = 4'd3;
  localparam op_t OP_STR = 4'd4;
  localparam op_t OP_JMP = 4'd5;
  localparam op_t OP_JZS = 4'd6;
  localparam op_t OP_JVS = 4'd7;
  localparam op_t OP_HLT = 4'd8;
  localparam op_t OP_XCH = 4'd9;
  localparam op_t OP_ADD = 4'd10;

  // Data store write request from the execute stage
  typedef struct packed {
    logic   en;
    daddr_t addr;
    word_t  data;
  } wr_req_t;

  // Architectural state after one instruction
  typedef struct packed {
    word_t acc;
    word_t b;
    logic  zero;
    logic  ovf;
    pc_t   pc;
    logic  halted;
    logic  bad;
  } result_t;

endpackage

/* src/amx_ram.sv */
module amx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/amx_dstore.sv */
module amx_dstore (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  amx_pkg::daddr_t  rd_addr,
  input  amx_pkg::wr_req_t wr,
  output amx_pkg::word_t   rd_data
);

  logic [amx_pkg::DATA_DEPTH-1:0] vld;
  logic                           rd_vld;
  logic                           fwd_hit;
  amx_pkg::word_t                 fwd_data;
  logic [amx_pkg::WORD_BITS-1:0]  ram_q;

  amx_ram #(
    .WIDTH (amx_pkg::WORD_BITS),
    .DEPTH (amx_pkg::DATA_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Written-word marks; an unwritten word reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // Read side info, captured with the read; forward a same-cycle store
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      rd_vld  <= vld[rd_addr];
      fwd_hit <= wr.en && (wr.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr.data;
    end
  end

  always_comb begin
    if (fwd_hit) begin
      rd_data = fwd_data;
    end else if (rd_vld) begin
      rd_data = amx_pkg::word_t'(ram_q);
    end else begin
      rd_data = '0;
    end
  end

endmodule

/* src/amx_exec.sv */
module amx_exec (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  amx_pkg::op_t           op,
  input  amx_pkg::daddr_t        addr,
  input  logic signed [amx_pkg::IMM_W-1:0] imm,
  input  logic [amx_pkg::TGT_W-1:0] tgt,
  input  amx_pkg::word_t         mem_data,
  output amx_pkg::wr_req_t       wr,
  output amx_pkg::result_t       res
);

  amx_pkg::word_t acc, b;
  logic           zero, ovf;
  amx_pkg::pc_t   pc;

  amx_pkg::word_t sum;
  logic           sum_ovf;
  amx_pkg::pc_t   pc_inc, pc_tgt;

  // Adder and overflow detect
  assign sum     = acc + b;
  assign sum_ovf = (acc[amx_pkg::WORD_BITS-1] == b[amx_pkg::WORD_BITS-1]) &&
                   (sum[amx_pkg::WORD_BITS-1] != acc[amx_pkg::WORD_BITS-1]);
  assign pc_inc  = pc + amx_pkg::PC_W'(1);
  assign pc_tgt  = amx_pkg::PC_W'(tgt);

  // Next state decode
  always_comb begin
    res.acc    = acc;
    res.b      = b;
    res.zero   = zero;
    res.ovf    = ovf;
    res.pc     = pc_inc;
    res.halted = 1'b0;
    res.bad    = 1'b0;
    wr.en      = 1'b0;
    wr.addr    = addr;
    wr.data    = acc;
    unique case (op)
      amx_pkg::OP_DEC: ;
      amx_pkg::OP_LDA: res.acc = mem_data;
      amx_pkg::OP_LDB: res.b = mem_data;
      amx_pkg::OP_LDI: res.acc = amx_pkg::WORD_BITS'(imm);
      amx_pkg::OP_STR: wr.en = go;
      amx_pkg::OP_JMP: res.pc = pc_tgt;
      amx_pkg::OP_JZS: if (zero) res.pc = pc_tgt;
      amx_pkg::OP_JVS: if (ovf) res.pc = pc_tgt;
      amx_pkg::OP_HLT: res.halted = 1'b1;
      amx_pkg::OP_XCH: begin
        res.acc = b;
        res.b   = acc;
      end
      amx_pkg::OP_ADD: begin
        res.acc  = sum;
        res.zero = (sum == '0);
        res.ovf  = sum_ovf;
      end
      default: res.bad = 1'b1;
    endcase
  end

  // Architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      b    <= '0;
      zero <= 1'b0;
      ovf  <= 1'b0;
      pc   <= '0;
    end else if (go) begin
      acc  <= res.acc;
      b    <= res.b;
      zero <= res.zero;
      ovf  <= res.ovf;
      pc   <= res.pc;
    end
  end

endmodule

/* src/accumulator_machine_execute.sv */
// Channel | Direction | Handshake          | Word
// in      | input     | in_valid/in_stall   | req_type, data_address, immediate_value, jump_target
// out     | output    | out_valid/out_stall | acc_value, b_value, zero_flag, overflow_flag,
//         |           |                     | next_pc, halted, bad_opcode
//
// One instruction per cycle sustained unless the output stalls. Stage 1 issues the
// data store read on accept, stage 2 executes and writes back; a stage 2 store to
// the word being read in that same cycle is forwarded.
// Reset clears registers, flags, PC and the written-word marks of the store.
// A stalled output word holds; input stalls only when both stages are full
// and the output word is stalled.
module accumulator_machine_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  req_type,
  input  logic [7:0]  data_address,
  input  logic signed [31:0] immediate_value,
  input  logic [7:0]  jump_target,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] acc_value,
  output logic signed [31:0] b_value,
  output logic        zero_flag,
  output logic        overflow_flag,
  output logic [7:0]  next_pc,
  output logic        halted,
  output logic        bad_opcode
);

  logic                    accept;
  logic                    s1_valid;
  logic                    s1_adv;
  amx_pkg::op_t            s1_op;
  amx_pkg::daddr_t         s1_addr;
  logic signed [amx_pkg::IMM_W-1:0] s1_imm;
  logic [amx_pkg::TGT_W-1:0] s1_tgt;
  amx_pkg::daddr_t         rd_addr;
  amx_pkg::word_t          mem_data;
  amx_pkg::wr_req_t        wr;
  amx_pkg::result_t        res;
  amx_pkg::result_t        out_r;

  // Handshake
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign rd_addr  = amx_pkg::DADDR_W'(data_address);

  // Stage 1 holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= req_type;
      s1_addr <= rd_addr;
      s1_imm  <= immediate_value;
      s1_tgt  <= jump_target;
    end
  end

  amx_dstore u_dstore (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (mem_data)
  );

  amx_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .go       (s1_adv),
    .op       (s1_op),
    .addr     (s1_addr),
    .imm      (s1_imm),
    .tgt      (s1_tgt),
    .mem_data (mem_data),
    .wr       (wr),
    .res      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign acc_value     = amx_pkg::OUT_W'(out_r.acc);
  assign b_value       = amx_pkg::OUT_W'(out_r.b);
  assign zero_flag     = out_r.zero;
  assign overflow_flag = out_r.ovf;
  assign next_pc       = amx_pkg::OUT_PC_W'(out_r.pc);
  assign halted        = out_r.halted;
  assign bad_opcode    = out_r.bad;

`ifndef ASSERT_OFF
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty stage 1");

  a_store_on_adv: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> s1_adv)
    else $error("data store written without an executing instruction");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(halted && bad_opcode))
    else $error("halted and bad_opcode both set");
`endif

endmodule
